@@ hdl/ati_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ati_pkg
// shared types, constants and anchor field helpers for the anchor table
// interpolator
// ----------------------------------------------------------------------------
package ati_pkg;

  localparam int AnchorW  = 33;
  localparam int PctW     = 15;
  localparam int ValW     = 17;
  localparam int RegSlots = 8;
  localparam int CfgAddrW = 6;
  localparam int CfgDataW = 64;
  localparam int CfgLsb   = 3;
  localparam int DivSteps = ValW;

  localparam logic signed [ValW-1:0] PctOne     = 17'sd256;
  localparam logic signed [ValW-1:0] PctHundred = 17'sd25600;
  localparam logic signed [ValW-1:0] ResMax     = 17'sd65535;
  localparam logic signed [ValW-1:0] ResMin     = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_LOW,
    RES_HIGH,
    RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     scan_init;
    logic     scan_step;
    logic     capture;
    logic     mul;
    logic     div_init;
    logic     div_step;
    logic     commit;
    res_sel_t sel;
  } ati_cmd_t;

  typedef struct packed {
    logic empty;
    logic below;
    logic above;
    logic hit;
    logic at_last;
    logic div_last;
  } ati_sts_t;

  // search key of an anchor: percent for forward, dB for inverse
  function automatic logic signed [ValW-1:0] anc_key(input logic [AnchorW-1:0] a,
                                                      input logic inv);
    logic signed [ValW-1:0] k;
    k = inv ? $signed(a[ValW-1:0]) : $signed({2'b00, a[AnchorW-2:ValW]});
    return k;
  endfunction

  // value of an anchor: dB for forward, percent for inverse
  function automatic logic signed [ValW-1:0] anc_val(input logic [AnchorW-1:0] a,
                                                      input logic inv);
    logic signed [ValW-1:0] v;
    v = inv ? $signed({2'b00, a[AnchorW-2:ValW]}) : $signed(a[ValW-1:0]);
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ati_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ati_regs
// apb anchor register file, one 33-bit anchor per 8-byte slot
// ----------------------------------------------------------------------------
module ati_regs #(
  parameter int ANCHOR_COUNT = 8
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              cfg_psel,
  input  logic                                              cfg_penable,
  input  logic                                              cfg_pwrite,
  input  logic [ati_pkg::CfgAddrW-1:0]                      cfg_paddr,
  input  logic [ati_pkg::CfgDataW-1:0]                      cfg_pwdata,
  output logic [ati_pkg::CfgDataW-1:0]                      cfg_prdata,
  output logic                                              cfg_pready,
  output logic [ANCHOR_COUNT-1:0][ati_pkg::AnchorW-1:0]     anchors
);
  import ati_pkg::*;

  localparam int IW = $clog2(ANCHOR_COUNT);

  logic [ANCHOR_COUNT-1:0][AnchorW-1:0] anchor_r;
  logic [CfgAddrW-CfgLsb-1:0]           slot;
  logic                                 in_range;
  logic                                 wr_en;

  assign slot       = cfg_paddr[CfgAddrW-1:CfgLsb];
  assign in_range   = int'(slot) < ANCHOR_COUNT;
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
    end else if (wr_en) begin
      anchor_r[slot[IW-1:0]] <= cfg_pwdata[AnchorW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (in_range) begin
      cfg_prdata = {{(CfgDataW-AnchorW){1'b0}}, anchor_r[slot[IW-1:0]]};
    end
  end

  assign anchors = anchor_r;

endmodule
`default_nettype wire

@@ hdl/ati_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ati_ctrl
// sequencer: extent check, segment scan, multiply, serial divide, result
// ----------------------------------------------------------------------------
module ati_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  input  ati_pkg::ati_sts_t sts,
  output ati_pkg::ati_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid
);
  import ati_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t   state_r, state_nxt;
  res_sel_t sel_r, sel_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;

  assign out_free  = ~out_valid_r | out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.empty) begin
            sel_nxt   = RES_EMPTY;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.below) begin
          sel_nxt   = RES_LOW;
          state_nxt = ST_DONE;
        end else if (sts.above) begin
          sel_nxt   = RES_HIGH;
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end else if (sts.at_last) begin
          sel_nxt   = RES_HIGH;
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          sel_nxt   = RES_INTERP;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= RES_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ati_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ati_dp
// datapath: table extent, segment registers, 17x17 multiplier, restoring
// divider one quotient bit per cycle, saturation and result register
// ----------------------------------------------------------------------------
module ati_dp #(
  parameter int ANCHOR_COUNT = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [ANCHOR_COUNT-1:0][ati_pkg::AnchorW-1:0] anchors,
  input  logic                                          in_inv,
  input  logic [ati_pkg::PctW-1:0]                      in_pct,
  input  logic signed [ati_pkg::ValW-1:0]               in_db,
  input  ati_pkg::ati_cmd_t                             cmd,
  output ati_pkg::ati_sts_t                             sts,
  output logic signed [ati_pkg::ValW-1:0]               res_value,
  output logic                                          res_empty
);
  import ati_pkg::*;

  localparam int IW  = $clog2(ANCHOR_COUNT);
  localparam int CW  = $clog2(ANCHOR_COUNT + 1);
  localparam int DCW = $clog2(DivSteps);

  // request and scan state
  logic                   inv_r;
  logic signed [ValW-1:0] q_r;
  logic [IW-1:0]          idx_r;
  logic signed [ValW-1:0] lo_k_r, lo_v_r;

  // segment operands
  logic [ValW-1:0]        dq_r, span_r;
  logic [ValW:0]          dv_r;
  logic signed [ValW-1:0] base_r;
  logic [2*ValW-1:0]      prod_r;
  logic [ValW-1:0]        rem_r, quo_r;
  logic [DCW-1:0]         div_cnt_r;

  logic signed [ValW-1:0] res_r;
  logic                   empty_r;

  // extent of the valid run
  logic                   run;
  logic [CW-1:0]          cnt;
  logic [IW-1:0]          last_idx;

  logic [AnchorW-1:0]     cur;
  logic signed [ValW-1:0] cur_k, cur_v, k0, v0;
  logic [ValW:0]          dq_full, span_full, dv_full, dv_abs;
  logic [ValW-1:0]        dv_mag;
  logic [ValW:0]          shifted;
  logic                   ge;
  logic [ValW+1:0]        quo_s, sum;
  logic signed [ValW-1:0] interp, res_nxt;

  always_comb begin
    run = 1'b1;
    cnt = '0;
    for (int i = 0; i < ANCHOR_COUNT; i++) begin
      if (run && anchors[i][AnchorW-1]) begin
        cnt = CW'(i + 1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign last_idx = IW'(cnt - CW'(1));

  assign cur   = anchors[idx_r];
  assign cur_k = anc_key(cur, inv_r);
  assign cur_v = anc_val(cur, inv_r);
  assign k0    = anc_key(anchors[0], inv_r);
  assign v0    = anc_val(anchors[0], inv_r);

  assign sts.empty    = ~anchors[0][AnchorW-1];
  assign sts.below    = q_r <= k0;
  assign sts.above    = q_r >= cur_k;
  assign sts.hit      = q_r <= cur_k;
  assign sts.at_last  = (idx_r == last_idx);
  assign sts.div_last = (div_cnt_r == DCW'(DivSteps - 1));

  assign dq_full   = {q_r[ValW-1], q_r} - {lo_k_r[ValW-1], lo_k_r};
  assign span_full = {cur_k[ValW-1], cur_k} - {lo_k_r[ValW-1], lo_k_r};
  assign dv_full   = {cur_v[ValW-1], cur_v} - {lo_v_r[ValW-1], lo_v_r};

  assign dv_abs = dv_r[ValW] ? (~dv_r + {{ValW{1'b0}}, 1'b1}) : dv_r;
  assign dv_mag = dv_abs[ValW-1:0];

  assign shifted = {rem_r, quo_r[ValW-1]};
  assign ge      = shifted >= {1'b0, span_r};

  // signed base plus signed quotient, then clamp to 17 bits
  assign quo_s = dv_r[ValW] ? (~{2'b00, quo_r} + {{(ValW+1){1'b0}}, 1'b1})
                            : {2'b00, quo_r};
  assign sum   = {{2{base_r[ValW-1]}}, base_r} + quo_s;

  always_comb begin
    if (!sum[ValW+1] && (sum[ValW] || sum[ValW-1])) begin
      interp = ResMax;
    end else if (sum[ValW+1] && !(sum[ValW] && sum[ValW-1])) begin
      interp = ResMin;
    end else begin
      interp = $signed(sum[ValW-1:0]);
    end
  end

  always_comb begin
    case (cmd.sel)
      RES_EMPTY:  res_nxt = '0;
      RES_LOW:    res_nxt = inv_r ? PctOne : v0;
      RES_HIGH:   res_nxt = inv_r ? PctHundred : cur_v;
      RES_INTERP: res_nxt = interp;
      default:    res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= last_idx;
      end else if (cmd.scan_init) begin
        idx_r <= IW'(1);
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmd.div_init) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inv_r <= in_inv;
      q_r   <= in_inv ? in_db : $signed({2'b00, in_pct});
    end
    if (cmd.scan_init) begin
      lo_k_r <= k0;
      lo_v_r <= v0;
    end else if (cmd.scan_step) begin
      lo_k_r <= cur_k;
      lo_v_r <= cur_v;
    end
    if (cmd.capture) begin
      dq_r   <= dq_full[ValW-1:0];
      span_r <= span_full[ValW-1:0];
      dv_r   <= dv_full;
      base_r <= lo_v_r;
    end
    if (cmd.mul) begin
      prod_r <= (2*ValW)'(dq_r) * (2*ValW)'(dv_mag);
    end
    if (cmd.div_init) begin
      rem_r <= prod_r[2*ValW-1:ValW];
      quo_r <= prod_r[ValW-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? shifted[ValW-1:0] - span_r : shifted[ValW-1:0];
      quo_r <= {quo_r[ValW-2:0], ge};
    end
    if (cmd.commit) begin
      res_r   <= res_nxt;
      empty_r <= (cmd.sel == RES_EMPTY);
    end
  end

  assign res_value = res_r;
  assign res_empty = empty_r;

endmodule
`default_nettype wire

@@ hdl/anchor_table_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anchor_table_interpolator
// piecewise linear volume curve, percent to dB and dB to percent
//
//   channel  dir  contents
//   in_      in   tdata {db_query, pct_query}, tuser req_type
//   out_     out  tdata {pad, result_value}, tuser table_empty
//   cfg_     in   apb, anchor i at byte 8*i, 64-bit data
//
// one request at a time; an empty table goes straight to the result, an
// end-of-curve one follows the extent check or the scan, an interpolated
// one the scan (one anchor per cycle), multiply and 17-step divider
// the result register lets the next request in while a result waits
// synchronous active-low reset clears the anchors and the sequencer
// ----------------------------------------------------------------------------
module anchor_table_interpolator #(
  parameter int ANCHOR_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // pct_query, db_query
  input  logic                           in_tuser,   // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // result_value
  output logic                           out_tuser,  // table_empty
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ati_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [ati_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [ati_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import ati_pkg::*;

  logic [ANCHOR_COUNT-1:0][AnchorW-1:0] anchors;
  ati_cmd_t                             cmd;
  ati_sts_t                             sts;
  logic signed [ValW-1:0]               res_value;
  logic                                 res_empty;

  ati_regs #(
    .ANCHOR_COUNT(ANCHOR_COUNT)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .anchors    (anchors)
  );

  ati_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_ready(out_tready),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready),
    .out_valid(out_tvalid)
  );

  ati_dp #(
    .ANCHOR_COUNT(ANCHOR_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .anchors  (anchors),
    .in_inv   (in_tuser),
    .in_pct   (in_tdata[PctW-1:0]),
    .in_db    ($signed(in_tdata[PctW+ValW-1:PctW])),
    .cmd      (cmd),
    .sts      (sts),
    .res_value(res_value),
    .res_empty(res_empty)
  );

  assign out_tdata = {{(24-ValW){1'b0}}, res_value};
  assign out_tuser = res_empty;

endmodule
`default_nettype wire

@@ hdl/ati_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ati_chk
// port-level checks for the anchor table interpolator
// ----------------------------------------------------------------------------
module ati_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  // a waiting result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request in flight at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // empty table gives zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("empty table with non-zero result");

  // nothing pending after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_pready)
    else $error("output valid after reset");

endmodule

bind anchor_table_interpolator ati_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_pready(cfg_pready)
);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the anchor table interpolator: anchor tables are
// loaded over apb between phases, percent and db lookups are streamed in with
// random gaps and back-pressure, and every result is checked against a
// behavioural model of the volume curve kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb;

  import ati_pkg::*;

  localparam int ANCHORS     = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 45;

  localparam bit REQ_FWD = 1'b0;
  localparam bit REQ_INV = 1'b1;

  typedef enum int {TBL_CURVE, TBL_EMPTY, TBL_SINGLE, TBL_WILD} table_kind_t;

  typedef struct {
    logic signed [ValW-1:0] level;
    logic                   empty;
  } level_t;

  class level_scoreboard;
    logic [AnchorW-1:0] anchor_copy[ANCHORS];
    level_t             pending_levels[$];
    int                 errors;

    function new();
      foreach (anchor_copy[i]) anchor_copy[i] = '0;
      errors = 0;
    endfunction

    function void set_anchor(int idx, logic [AnchorW-1:0] value);
      anchor_copy[idx] = value;
    endfunction

    // interpolate along the valid run of anchors starting at slot zero
    function level_t curve_lookup(bit inverse, logic [PctW-1:0] pct,
                                  logic signed [ValW-1:0] db);
      longint key[ANCHORS];
      longint val[ANCHORS];
      longint pc_v, db_v, q, lo, hi, res, span;
      int     n;
      bit     found;
      level_t r;
      n = 0;
      for (int i = 0; i < ANCHORS && n == i; i++) begin
        if (anchor_copy[i][AnchorW-1]) begin
          pc_v = longint'(anchor_copy[i][AnchorW-2:ValW]);
          db_v = longint'($signed(anchor_copy[i][ValW-1:0]));
          key[i] = inverse ? db_v : pc_v;
          val[i] = inverse ? pc_v : db_v;
          n++;
        end
      end
      r.empty = (n == 0);
      r.level = '0;
      if (n == 0) return r;
      if (inverse) begin
        q  = longint'(db);
        lo = longint'(PctOne);
        hi = longint'(PctHundred);
      end else begin
        q  = longint'(pct);
        lo = val[0];
        hi = val[n-1];
      end
      found = 1'b0;
      if (q <= key[0]) res = lo;
      else if (q >= key[n-1]) res = hi;
      else begin
        res = hi;
        for (int i = 1; i < n; i++) begin
          if (!found && q <= key[i]) begin
            found = 1'b1;
            span  = key[i] - key[i-1];
            if (span == 0) res = val[i];
            else res = val[i-1] + ((q - key[i-1]) * (val[i] - val[i-1])) / span;
          end
        end
      end
      if (res > longint'(ResMax)) res = longint'(ResMax);
      if (res < longint'(ResMin)) res = longint'(ResMin);
      r.level = res[ValW-1:0];
      return r;
    endfunction

    function void note_request(bit inverse, logic [PctW-1:0] pct,
                               logic signed [ValW-1:0] db);
      pending_levels.push_back(curve_lookup(inverse, pct, db));
    endfunction

    function void check_result(logic signed [ValW-1:0] level, logic empty);
      level_t exp_r;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result level %0d empty %0b", $time, level, empty);
        errors++;
        return;
      end
      exp_r = pending_levels.pop_front();
      if (level !== exp_r.level) begin
        $display("%0t: result_value expected %0d actual %0d", $time, exp_r.level, level);
        errors++;
      end
      if (empty !== exp_r.empty) begin
        $display("%0t: table_empty expected %0b actual %0b", $time, exp_r.empty, empty);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_levels.size();
    endfunction

    function void report_leftovers();
      foreach (pending_levels[i]) begin
        $display("%0t: missing result expected %0d empty %0b actual none", $time,
                 pending_levels[i].level, pending_levels[i].empty);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;    // pct_query, db_query
  logic                in_tuser;    // req_type
  logic                out_tvalid;
  logic                out_tready;
  logic [23:0]         out_tdata;   // result_value, pad
  logic                out_tuser;   // table_empty
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  level_scoreboard    levels = new();
  logic [AnchorW-1:0] cur_anchor[ANCHORS];
  bit                 tx_idle;
  bit                 rx_idle;
  bit                 hold_request;
  int                 quiet_cycles;

  anchor_table_interpolator #(.ANCHOR_COUNT(ANCHORS)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      levels.check_result($signed(out_tdata[ValW-1:0]), out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [AnchorW-1:0] anchor(int pct, int db);
    return {1'b1, 15'(pct), 17'(db)};
  endfunction

  task automatic write_anchor(int idx, logic [AnchorW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAddrW'(idx << CfgLsb);
    cfg_pwdata  <= CfgDataW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    levels.set_anchor(idx, value);
    cur_anchor[idx] = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_table(logic [AnchorW-1:0] regs[ANCHORS]);
    for (int i = 0; i < ANCHORS; i++) write_anchor(i, regs[i]);
  endtask

  task automatic send_request(bit inverse, logic [PctW-1:0] pct, logic [ValW-1:0] db);
    int gap;
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {db, pct};
    in_tuser  <= inverse;
    do @(posedge clk); while (!in_tready);
    levels.note_request(inverse, pct, $signed(db));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (levels.outstanding() != 0) @(posedge clk);
  endtask

  task automatic load_table(table_kind_t kind);
    logic [AnchorW-1:0] regs[ANCHORS];
    int pq[$];
    int dq[$];
    int n;
    for (int i = 0; i < ANCHORS; i++) regs[i] = AnchorW'({$urandom, $urandom});
    case (kind)
      TBL_EMPTY: begin
        regs[0][AnchorW-1] = 1'b0;
      end
      TBL_WILD: begin
        for (int i = 0; i < ANCHORS; i++) regs[i][AnchorW-1] = ($urandom_range(0, 7) != 0);
      end
      default: begin
        n = (kind == TBL_SINGLE) ? 1 : $urandom_range(2, ANCHORS);
        for (int i = 0; i < n; i++) begin
          pq.push_back($urandom_range(0, 25600));
          dq.push_back(-int'($urandom_range(0, 36864)));
        end
        pq.sort();
        if ($urandom_range(0, 3) == 0) dq.rsort();
        else dq.sort();
        for (int i = 0; i < n; i++) regs[i] = anchor(pq[i], dq[i]);
        if (n < ANCHORS) regs[n][AnchorW-1] = 1'b0;
      end
    endcase
    write_table(regs);
  endtask

  // mostly in-range queries, some on or beside anchor keys, some anywhere in the field
  task automatic random_request();
    bit              inverse;
    logic [PctW-1:0] pct;
    logic [ValW-1:0] db;
    int              idx;
    inverse = $urandom_range(0, 1);
    pct     = PctW'($urandom);
    db      = ValW'($urandom);
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3: begin
        idx = $urandom_range(0, ANCHORS - 1);
        pct = cur_anchor[idx][AnchorW-2:ValW] + PctW'($urandom_range(0, 2) - 1);
        db  = cur_anchor[idx][ValW-1:0] + ValW'($urandom_range(0, 2) - 1);
      end
      default: begin
        pct = PctW'($urandom_range(0, 25600));
        db  = ValW'(-int'($urandom_range(0, 36864)));
      end
    endcase
    send_request(inverse, pct, db);
  endtask

  initial begin
    logic [AnchorW-1:0] regs[ANCHORS];
    table_kind_t        kind;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    hold_request = 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    foreach (cur_anchor[i]) cur_anchor[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table straight out of reset
    send_request(REQ_FWD, 15'd12800, -17'sd100);
    send_request(REQ_INV, 15'd0, -17'sd20000);
    drain();

    // ordinary rising curve
    regs = '{anchor(256, -36864), anchor(6400, -12800), anchor(12800, -5120),
             anchor(25600, 0), '0, '0, '0, '0};
    write_table(regs);
    send_request(REQ_FWD, 15'd0, 17'h0);
    send_request(REQ_FWD, 15'd256, 17'h0);
    send_request(REQ_FWD, 15'd3000, 17'h1ffff);
    send_request(REQ_FWD, 15'd6400, 17'h0);
    send_request(REQ_FWD, 15'd20000, 17'h0);
    send_request(REQ_FWD, 15'd25600, 17'h0);
    send_request(REQ_FWD, 15'h7fff, 17'h1ffff);
    send_request(REQ_INV, 15'h7fff, 17'h10000);
    send_request(REQ_INV, 15'd0, ValW'(-36864));
    send_request(REQ_INV, 15'd0, ValW'(-20000));
    send_request(REQ_INV, 15'd0, ValW'(-5120));
    send_request(REQ_INV, 15'd0, 17'h1ffff);
    send_request(REQ_INV, 15'd0, 17'h0);
    send_request(REQ_INV, 15'd0, 17'h0ffff);
    drain();

    // single anchor
    regs = '{anchor(9000, -3000), '0, '0, '0, '0, '0, '0, '0};
    write_table(regs);
    send_request(REQ_FWD, 15'd100, 17'h0);
    send_request(REQ_INV, 15'd0, ValW'(-4000));
    send_request(REQ_INV, 15'd0, 17'h0);
    drain();

    // falling curve with duplicate keys, then a gap with a stray valid anchor
    regs = '{anchor(0, 0), anchor(10000, -777), anchor(10000, -777),
             anchor(25600, -30000), '0, anchor(30000, 5000), '0, '0};
    write_table(regs);
    send_request(REQ_FWD, 15'd3333, 17'h0);
    send_request(REQ_FWD, 15'd17000, 17'h0);
    send_request(REQ_FWD, 15'd29000, 17'h0);
    send_request(REQ_INV, 15'd0, ValW'(-777));
    drain();

    // every anchor at the field maxima
    regs = '{default: '1};
    write_table(regs);
    send_request(REQ_FWD, 15'h7fff, 17'h0);
    send_request(REQ_INV, 15'h0, 17'h0ffff);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) kind = TBL_EMPTY;
      else if (p == 4) kind = TBL_SINGLE;
      else if (p == 5 || p == 8) kind = TBL_WILD;
      else kind = TBL_CURVE;
      load_table(kind);
      tx_idle = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 3) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) random_request();
      drain();
    end

    repeat (40) @(posedge clk);
    levels.report_leftovers();
    if (levels.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
